// ===== design/cpid_pkg.sv =====
// Shared types, register indexes, reset values and sequencer codes for the
// cascaded position/speed PID regulator. Used by every file in design/.
package cpid_pkg;

  // Default number of motors with their own loop state
  localparam int MOTOR_COUNT_DEF = 4;

  // Word widths
  localparam int ERR_W   = 17;  // loop error, signed integer
  localparam int INTEG_W = 24;  // integrator, signed, 8 fraction bits
  localparam int PROD_W  = 35;  // gain times error difference, signed
  localparam int ACC_W   = 37;  // sum of the three terms, signed
  localparam int GAIN_W  = 48;  // kp, ki, kd packed, each Q8.8
  localparam int LIM_W   = 15;
  localparam int DB_W    = 13;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAINS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POSITION_GAINS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_CLAMP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_DEADBAND   = 3'd4;

  // Register reset values
  localparam logic [GAIN_W-1:0] SPEED_GAINS_RST    = 48'd550259134976;
  localparam logic [GAIN_W-1:0] POSITION_GAINS_RST = 48'd661424963763;
  localparam logic [LIM_W-1:0]  OUTPUT_LIMIT_RST   = 15'd30000;
  localparam logic [LIM_W-1:0]  INTEG_CLAMP_RST    = 15'd10000;
  localparam logic [DB_W-1:0]   POS_DEADBAND_RST   = 13'd20;

  // Loop mode codes
  localparam logic OP_SPEED    = 1'b0;
  localparam logic OP_POSITION = 1'b1;

  // Input item
  typedef struct packed {
    logic              op;
    logic [1:0]        motor_id;
    logic signed [15:0] target;
    logic [12:0]       measured_angle;
    logic signed [15:0] measured_speed;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [1:0]         motor_number;
    logic signed [15:0] voltage;
    logic               in_deadband;
  } out_item_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_I,
    ST_INTEG,
    ST_PROP,
    ST_DERIV,
    ST_TRUNC,
    ST_SAT,
    ST_EMIT
  } state_t;

  // Operations of the shared multiply-accumulate unit
  typedef enum logic [2:0] {
    ALU_NOP,
    ALU_MUL_I,
    ALU_INTEG,
    ALU_PROP,
    ALU_DERIV,
    ALU_TRUNC
  } alu_op_t;

  // Write strobes into the per-motor loop state
  typedef struct packed {
    logic integ_we;
    logic last_we;
  } mem_wr_t;

endpackage

// ===== design/cpid_alu.sv =====
// Shared multiply-accumulate unit of the PID regulator: one signed multiplier,
// product and accumulator registers, integrator clamp, truncation and output
// saturation. Depends on cpid_pkg.
module cpid_alu (
  input  logic                                clk,
  input  cpid_pkg::alu_op_t                   op,
  input  logic [cpid_pkg::GAIN_W-1:0]         gains,
  input  logic signed [cpid_pkg::ERR_W-1:0]   err,
  input  logic signed [cpid_pkg::ERR_W-1:0]   prev_err,
  input  logic signed [cpid_pkg::INTEG_W-1:0] integ,
  input  logic [cpid_pkg::LIM_W-1:0]          ilim,
  input  logic [cpid_pkg::LIM_W-1:0]          olim,
  output logic signed [cpid_pkg::INTEG_W-1:0] integ_new,
  output logic signed [15:0]                  sat_out
);

  logic [15:0]                         k;
  logic signed [16:0]                  mul_a;
  logic signed [cpid_pkg::ERR_W:0]     mul_b;
  logic signed [cpid_pkg::ERR_W:0]     err_x;
  logic signed [cpid_pkg::ERR_W:0]     diff;
  logic signed [cpid_pkg::PROD_W-1:0]  product;
  logic signed [cpid_pkg::PROD_W-1:0]  prod_r;
  logic signed [cpid_pkg::PROD_W-1:0]  isum;
  logic signed [cpid_pkg::PROD_W-1:0]  ilim_q;
  logic signed [cpid_pkg::ACC_W-1:0]   acc_r;
  logic signed [cpid_pkg::ACC_W-1:0]   acc_nxt;
  logic signed [cpid_pkg::ACC_W-1:0]   tsum;
  logic signed [cpid_pkg::ACC_W-1:0]   olim_x;

  // Operand selection: ki*err, kp*err, kd*(err - last)
  assign err_x = {err[cpid_pkg::ERR_W-1], err};
  assign diff  = err_x - $signed({prev_err[cpid_pkg::ERR_W-1], prev_err});

  always_comb begin
    k     = 16'd0;
    mul_b = err_x;
    case (op)
      cpid_pkg::ALU_MUL_I: k = gains[31:16];
      cpid_pkg::ALU_INTEG: k = gains[15:0];
      cpid_pkg::ALU_PROP: begin
        k     = gains[47:32];
        mul_b = diff;
      end
      default: k = 16'd0;
    endcase
  end

  assign mul_a   = $signed({1'b0, k});
  assign product = mul_a * mul_b;

  // Integrator update with a symmetric clamp at the integrator limit, in whole units
  assign isum   = $signed({{(cpid_pkg::PROD_W-cpid_pkg::INTEG_W){integ[cpid_pkg::INTEG_W-1]}},
                           integ}) + prod_r;
  assign ilim_q = $signed({12'd0, ilim, 8'd0});

  always_comb begin
    if (isum > ilim_q) begin
      integ_new = ilim_q[cpid_pkg::INTEG_W-1:0];
    end else if (isum < -ilim_q) begin
      integ_new = cpid_pkg::INTEG_W'(-ilim_q);
    end else begin
      integ_new = isum[cpid_pkg::INTEG_W-1:0];
    end
  end

  // Truncation toward zero: add 255 to negative sums before the shift
  assign tsum = acc_r + $signed({{(cpid_pkg::ACC_W-8){1'b0}}, {8{acc_r[cpid_pkg::ACC_W-1]}}});

  always_comb begin
    acc_nxt = acc_r;
    case (op) inside
      cpid_pkg::ALU_INTEG: begin
        acc_nxt = $signed({{(cpid_pkg::ACC_W-cpid_pkg::INTEG_W){integ_new[cpid_pkg::INTEG_W-1]}},
                           integ_new});
      end
      cpid_pkg::ALU_PROP,
      cpid_pkg::ALU_DERIV: begin
        acc_nxt = acc_r + $signed({{(cpid_pkg::ACC_W-cpid_pkg::PROD_W){prod_r[cpid_pkg::PROD_W-1]}},
                                   prod_r});
      end
      cpid_pkg::ALU_TRUNC: acc_nxt = tsum >>> 8;
      default: acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= product;
    acc_r  <= acc_nxt;
  end

  // Output saturation of the truncated whole value
  assign olim_x = $signed({{(cpid_pkg::ACC_W-cpid_pkg::LIM_W){1'b0}}, olim});

  always_comb begin
    if (acc_r > olim_x) begin
      sat_out = $signed({1'b0, olim});
    end else if (acc_r < -olim_x) begin
      sat_out = -$signed({1'b0, olim});
    end else begin
      sat_out = acc_r[15:0];
    end
  end

endmodule

// ===== design/cpid_loop_mem.sv =====
// Per-motor loop state: speed and position integrators and last errors,
// cleared by reset. Depends on cpid_pkg.
module cpid_loop_mem #(
  parameter int MOTOR_COUNT = cpid_pkg::MOTOR_COUNT_DEF,
  parameter int IDX_W       = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [IDX_W-1:0]                    idx,
  input  logic                                loop_pos,
  input  cpid_pkg::mem_wr_t                   wr,
  input  logic signed [cpid_pkg::INTEG_W-1:0] integ_wdata,
  input  logic signed [cpid_pkg::ERR_W-1:0]   last_wdata,
  output logic signed [cpid_pkg::INTEG_W-1:0] integ_rdata,
  output logic signed [cpid_pkg::ERR_W-1:0]   last_rdata
);

  logic signed [cpid_pkg::INTEG_W-1:0] spd_integ_r [MOTOR_COUNT];
  logic signed [cpid_pkg::INTEG_W-1:0] pos_integ_r [MOTOR_COUNT];
  logic signed [cpid_pkg::ERR_W-1:0]   spd_last_r  [MOTOR_COUNT];
  logic signed [cpid_pkg::ERR_W-1:0]   pos_last_r  [MOTOR_COUNT];

  // State of the loop being worked on
  assign integ_rdata = loop_pos ? pos_integ_r[idx] : spd_integ_r[idx];
  assign last_rdata  = loop_pos ? pos_last_r[idx]  : spd_last_r[idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        spd_integ_r[i] <= '0;
        pos_integ_r[i] <= '0;
        spd_last_r[i]  <= '0;
        pos_last_r[i]  <= '0;
      end
    end else begin
      if (wr.integ_we) begin
        if (loop_pos) begin
          pos_integ_r[idx] <= integ_wdata;
        end else begin
          spd_integ_r[idx] <= integ_wdata;
        end
      end
      if (wr.last_we) begin
        if (loop_pos) begin
          pos_last_r[idx] <= last_wdata;
        end else begin
          spd_last_r[idx] <= last_wdata;
        end
      end
    end
  end

endmodule

// ===== design/cascaded_position_speed_pid.sv =====
// Top level of the cascaded position/speed PID regulator: configuration
// registers, sequencer and result register. Uses cpid_pkg, cpid_alu, cpid_loop_mem.
//
// One item is taken at a time through in_valid/in_ready; in_ready is high only
// while the sequencer is idle. Each PID pass runs six steps on the single
// shared multiply-accumulate unit (integral product, integrator clamp,
// proportional and derivative products, truncation, saturation). A speed
// mode item runs the speed pass only; a position mode item runs the position
// pass first and hands its setpoint on to the speed pass.
// A motor number at or beyond MOTOR_COUNT gives voltage 0 without a pass.
// A result waits in the output register; if it has not been taken when the
// next one is ready, the sequencer holds until out_ready. Configuration
// writes are accepted in every cycle and take effect at once.
module cascaded_position_speed_pid #(
  parameter int MOTOR_COUNT = cpid_pkg::MOTOR_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  cpid_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output cpid_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cpid_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cpid_pkg::GAIN_W-1:0]       cfg_data
);

  localparam int IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

  // Configuration registers
  logic [cpid_pkg::GAIN_W-1:0] spd_gains_r;
  logic [cpid_pkg::GAIN_W-1:0] pos_gains_r;
  logic [cpid_pkg::LIM_W-1:0]  olim_r;
  logic [cpid_pkg::LIM_W-1:0]  ilim_r;
  logic [cpid_pkg::DB_W-1:0]   db_r;

  // Sequencer and item registers
  cpid_pkg::state_t                  state_r, state_nxt;
  logic                              loop_r, loop_nxt;
  logic [1:0]                        motor_r, motor_nxt;
  logic signed [15:0]                speed_r, speed_nxt;
  logic signed [cpid_pkg::ERR_W-1:0] err_r, err_nxt;
  logic                              dead_r, dead_nxt;
  logic signed [15:0]                volt_r, volt_nxt;
  logic                              out_valid_r, out_valid_nxt;
  cpid_pkg::out_item_t               out_data_r, out_data_nxt;

  // Control to the shared unit and the loop store
  cpid_pkg::alu_op_t                   alu_op;
  cpid_pkg::mem_wr_t                   mem_wr;
  logic                                in_xfer;
  logic                                out_load;
  logic                                id_ok;
  logic signed [cpid_pkg::ERR_W-1:0]   perr;
  logic [cpid_pkg::ERR_W-1:0]          pmag;
  logic signed [cpid_pkg::ERR_W-1:0]   serr;
  logic signed [15:0]                  setpoint;
  logic signed [cpid_pkg::INTEG_W-1:0] integ_cur;
  logic signed [cpid_pkg::INTEG_W-1:0] integ_new;
  logic signed [cpid_pkg::ERR_W-1:0]   last_cur;
  logic signed [15:0]                  sat_out;

  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spd_gains_r <= cpid_pkg::SPEED_GAINS_RST;
      pos_gains_r <= cpid_pkg::POSITION_GAINS_RST;
      olim_r      <= cpid_pkg::OUTPUT_LIMIT_RST;
      ilim_r      <= cpid_pkg::INTEG_CLAMP_RST;
      db_r        <= cpid_pkg::POS_DEADBAND_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cpid_pkg::CFG_SPEED_GAINS:    spd_gains_r <= cfg_data;
        cpid_pkg::CFG_POSITION_GAINS: pos_gains_r <= cfg_data;
        cpid_pkg::CFG_OUTPUT_LIMIT:   olim_r      <= cfg_data[cpid_pkg::LIM_W-1:0];
        cpid_pkg::CFG_INTEG_CLAMP:    ilim_r      <= cfg_data[cpid_pkg::LIM_W-1:0];
        cpid_pkg::CFG_POS_DEADBAND:   db_r        <= cfg_data[cpid_pkg::DB_W-1:0];
        default: ;
      endcase
    end
  end

  // Errors and deadband test of an arriving item
  assign id_ok = 32'(in_data.motor_id) < MOTOR_COUNT;
  assign perr  = $signed({in_data.target[15], in_data.target})
               - $signed({4'd0, in_data.measured_angle});
  assign pmag  = perr[cpid_pkg::ERR_W-1] ? 17'(-perr) : 17'(perr);
  assign serr  = $signed({in_data.target[15], in_data.target})
               - $signed({in_data.measured_speed[15], in_data.measured_speed});

  // Speed setpoint handed on from the position pass
  assign setpoint = dead_r ? 16'sd0 : sat_out;

  assign in_xfer  = in_valid && in_ready;
  assign out_load = (state_r == cpid_pkg::ST_EMIT) && (!out_valid_r || out_ready);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cpid_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = id_ok ? cpid_pkg::ST_MUL_I : cpid_pkg::ST_EMIT;
        end
      end
      cpid_pkg::ST_MUL_I: state_nxt = cpid_pkg::ST_INTEG;
      cpid_pkg::ST_INTEG: state_nxt = cpid_pkg::ST_PROP;
      cpid_pkg::ST_PROP:  state_nxt = cpid_pkg::ST_DERIV;
      cpid_pkg::ST_DERIV: state_nxt = cpid_pkg::ST_TRUNC;
      cpid_pkg::ST_TRUNC: state_nxt = cpid_pkg::ST_SAT;
      cpid_pkg::ST_SAT: begin
        state_nxt = loop_r ? cpid_pkg::ST_MUL_I : cpid_pkg::ST_EMIT;
      end
      cpid_pkg::ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = cpid_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cpid_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready        = 1'b0;
    alu_op          = cpid_pkg::ALU_NOP;
    mem_wr.integ_we = 1'b0;
    mem_wr.last_we  = 1'b0;
    unique case (state_r)
      cpid_pkg::ST_IDLE:  in_ready = 1'b1;
      cpid_pkg::ST_MUL_I: alu_op   = cpid_pkg::ALU_MUL_I;
      cpid_pkg::ST_INTEG: begin
        alu_op          = cpid_pkg::ALU_INTEG;
        mem_wr.integ_we = 1'b1;
      end
      cpid_pkg::ST_PROP:  alu_op = cpid_pkg::ALU_PROP;
      cpid_pkg::ST_DERIV: alu_op = cpid_pkg::ALU_DERIV;
      cpid_pkg::ST_TRUNC: alu_op = cpid_pkg::ALU_TRUNC;
      cpid_pkg::ST_SAT:   mem_wr.last_we = 1'b1;
      cpid_pkg::ST_EMIT:  ;
      default: ;
    endcase
  end

  // Item registers and result register
  always_comb begin
    loop_nxt      = loop_r;
    motor_nxt     = motor_r;
    speed_nxt     = speed_r;
    err_nxt       = err_r;
    dead_nxt      = dead_r;
    volt_nxt      = volt_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (in_xfer) begin
      motor_nxt = in_data.motor_id;
      speed_nxt = in_data.measured_speed;
      volt_nxt  = 16'sd0;
      if (in_data.op == cpid_pkg::OP_POSITION) begin
        loop_nxt = 1'b1;
        err_nxt  = perr;
        dead_nxt = id_ok && (pmag < {4'd0, db_r});
      end else begin
        loop_nxt = 1'b0;
        err_nxt  = serr;
        dead_nxt = 1'b0;
      end
    end

    // End of a pass: hand the setpoint on, or keep the voltage
    if (state_r == cpid_pkg::ST_SAT) begin
      if (loop_r) begin
        loop_nxt = 1'b0;
        err_nxt  = $signed({setpoint[15], setpoint}) - $signed({speed_r[15], speed_r});
      end else begin
        volt_nxt = sat_out;
      end
    end

    if (out_load) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.motor_number = motor_r;
      out_data_nxt.voltage      = volt_r;
      out_data_nxt.in_deadband  = dead_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cpid_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    loop_r     <= loop_nxt;
    motor_r    <= motor_nxt;
    speed_r    <= speed_nxt;
    err_r      <= err_nxt;
    dead_r     <= dead_nxt;
    volt_r     <= volt_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Per-motor loop state
  cpid_loop_mem #(
    .MOTOR_COUNT (MOTOR_COUNT),
    .IDX_W       (IDX_W)
  ) u_loop_mem (
    .clk         (clk),
    .rst_n       (rst_n),
    .idx         (IDX_W'(motor_r)),
    .loop_pos    (loop_r),
    .wr          (mem_wr),
    .integ_wdata (integ_new),
    .last_wdata  (err_r),
    .integ_rdata (integ_cur),
    .last_rdata  (last_cur)
  );

  // Shared multiply-accumulate unit
  cpid_alu u_alu (
    .clk       (clk),
    .op        (alu_op),
    .gains     (loop_r ? pos_gains_r : spd_gains_r),
    .err       (err_r),
    .prev_err  (last_cur),
    .integ     (integ_cur),
    .ilim      (ilim_r),
    .olim      (olim_r),
    .integ_new (integ_new),
    .sat_out   (sat_out)
  );

endmodule

// ===== design/cpid_check.sv =====
// Port-level checks of the cascaded PID regulator, bound to the top level.
// Depends on cpid_pkg and cascaded_position_speed_pid.
module cpid_check (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input cpid_pkg::in_item_t             in_data,
  input logic                           out_valid,
  input logic                           out_ready,
  input cpid_pkg::out_item_t            out_data
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A waiting input item holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input item changed while waiting");

  // One item at a time: no transfer in the cycle after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is at work");

  // Saturation is symmetric, so the most negative code never appears
  a_volt_sym: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.voltage != 16'sh8000)
    else $error("voltage outside symmetric limit");

  // Reset leaves no result pending
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind cascaded_position_speed_pid cpid_check u_cpid_check (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for cascaded_position_speed_pid: queue-fed driver,
// stalling receiver, result monitor and a loop predictor.
// Depends on design/cpid_pkg.sv and design/cascaded_position_speed_pid.sv.
module tb;

  localparam int MOTORS      = cpid_pkg::MOTOR_COUNT_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 20;    // longer than a position mode item takes
  localparam int HOLD_LEN    = 300;

  // Clock, reset and DUT ports
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  cpid_pkg::in_item_t    in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  cpid_pkg::out_item_t   out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [cpid_pkg::CFG_IDX_W-1:0] cfg_index = cpid_pkg::CFG_SPEED_GAINS;
  logic [cpid_pkg::GAIN_W-1:0]    cfg_data = '0;

  cascaded_position_speed_pid #(.MOTOR_COUNT(MOTORS)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Predictor copy of the registers and per-motor loop state
  logic [cpid_pkg::GAIN_W-1:0] spd_gains = cpid_pkg::SPEED_GAINS_RST;
  logic [cpid_pkg::GAIN_W-1:0] pos_gains = cpid_pkg::POSITION_GAINS_RST;
  logic [cpid_pkg::LIM_W-1:0]  out_lim   = cpid_pkg::OUTPUT_LIMIT_RST;
  logic [cpid_pkg::LIM_W-1:0]  integ_lim = cpid_pkg::INTEG_CLAMP_RST;
  logic [cpid_pkg::DB_W-1:0]   pos_db    = cpid_pkg::POS_DEADBAND_RST;

  logic signed [cpid_pkg::ERR_W-1:0]   spd_last  [MOTORS] = '{default: '0};
  logic signed [cpid_pkg::INTEG_W-1:0] spd_integ [MOTORS] = '{default: '0};
  logic signed [cpid_pkg::ERR_W-1:0]   pos_last  [MOTORS] = '{default: '0};
  logic signed [cpid_pkg::INTEG_W-1:0] pos_integ [MOTORS] = '{default: '0};

  cpid_pkg::in_item_t  cmd_queue[$];
  cpid_pkg::out_item_t voltage_expect_q[$];

  int err_count   = 0;
  int n_sent      = 0;
  int n_checked   = 0;
  int n_settings  = 1;
  int n_dead      = 0;
  int cycles      = 0;
  int hold_req    = 0;
  int hold_seen   = 0;

  function automatic longint clamp_sym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // One PID pass on the chosen loop of motor m; updates that loop's state
  function automatic longint pid_pass(bit pos_loop, int m, longint err);
    logic [cpid_pkg::GAIN_W-1:0] g;
    longint kp, ki, kd, ilim, integ, last, sum, whole;
    g     = pos_loop ? pos_gains : spd_gains;
    kp    = longint'(g[15:0]);
    ki    = longint'(g[31:16]);
    kd    = longint'(g[47:32]);
    ilim  = longint'(integ_lim) * 256;
    integ = pos_loop ? longint'(pos_integ[m]) : longint'(spd_integ[m]);
    last  = pos_loop ? longint'(pos_last[m]) : longint'(spd_last[m]);
    integ = clamp_sym(integ + ki * err, ilim);
    sum   = integ + kp * err + kd * (err - last);
    // truncate toward zero, dropping the 8 fraction bits
    whole = (sum >= 0) ? (sum >>> 8) : -((-sum) >>> 8);
    if (pos_loop) begin
      pos_integ[m] = cpid_pkg::INTEG_W'(integ);
      pos_last[m]  = cpid_pkg::ERR_W'(err);
    end else begin
      spd_integ[m] = cpid_pkg::INTEG_W'(integ);
      spd_last[m]  = cpid_pkg::ERR_W'(err);
    end
    return clamp_sym(whole, longint'(out_lim));
  endfunction

  // Expected voltage command for one accepted input transfer
  function automatic cpid_pkg::out_item_t regulate(cpid_pkg::in_item_t it);
    cpid_pkg::out_item_t res;
    longint    tgt, perr, mag, setp, volt;
    int        m;
    tgt  = longint'($signed(it.target));
    setp = tgt;
    volt = 0;
    m    = int'(it.motor_id);
    res.in_deadband = 1'b0;
    if (m < MOTORS) begin
      if (it.op == cpid_pkg::OP_POSITION) begin
        perr = tgt - longint'(it.measured_angle);
        mag  = (perr < 0) ? -perr : perr;
        setp = pid_pass(1'b1, m, perr);
        if (mag < longint'(pos_db)) begin
          setp = 0;
          res.in_deadband = 1'b1;
        end
      end
      volt = pid_pass(1'b0, m, setp - longint'($signed(it.measured_speed)));
    end
    res.motor_number = it.motor_id;
    res.voltage      = 16'(volt);
    return res;
  endfunction

  // Input driver: bursts of transfers separated by random gaps
  cpid_pkg::in_item_t nxt_data;
  logic               nxt_valid;
  int                 burst_left = 0;
  int                 gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_data    <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      nxt_valid = in_valid;
      nxt_data  = in_data;
      if (in_valid && in_ready) begin
        voltage_expect_q.push_back(regulate(in_data));
        n_sent++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_queue.size() > 0) begin
          nxt_data  = cmd_queue.pop_front();
          nxt_valid = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end
      in_valid <= nxt_valid;
      in_data  <= nxt_data;
    end
  end

  // Receiver: stall pattern changes every so often; long hold-off on request
  int   stall_mode = 0;
  int   mode_left = 0;
  int   hold_left = 0;
  int   stall_tick = 0;
  logic nxt_ready;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      stall_tick++;
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 2);
          mode_left  = $urandom_range(20, 120);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0:       nxt_ready = 1'b1;
          1:       nxt_ready = ($urandom_range(0, 1) == 1);
          default: nxt_ready = ((stall_tick % 4) == 0);
        endcase
      end
      out_ready <= nxt_ready;
    end
  end

  // Result monitor: compare each transfer with the oldest expectation
  cpid_pkg::out_item_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (voltage_expect_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual motor %0d voltage %0d db %0b",
                 $time, out_data.motor_number, out_data.voltage, out_data.in_deadband);
        err_count++;
      end else begin
        want = voltage_expect_q.pop_front();
        n_checked++;
        if (want.in_deadband) n_dead++;
        if (out_data.motor_number !== want.motor_number) begin
          $display("%0t: motor_number mismatch: expected %0d, actual %0d",
                   $time, want.motor_number, out_data.motor_number);
          err_count++;
        end
        if (out_data.voltage !== want.voltage) begin
          $display("%0t: voltage mismatch (motor %0d): expected %0d, actual %0d",
                   $time, want.motor_number, want.voltage, out_data.voltage);
          err_count++;
        end
        if (out_data.in_deadband !== want.in_deadband) begin
          $display("%0t: in_deadband mismatch (motor %0d): expected %0b, actual %0b",
                   $time, want.motor_number, want.in_deadband, out_data.in_deadband);
          err_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, voltage_expect_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Register write through the configuration channel
  task automatic write_reg(logic [cpid_pkg::CFG_IDX_W-1:0] idx,
                           logic [cpid_pkg::GAIN_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      cpid_pkg::CFG_SPEED_GAINS:    spd_gains = val;
      cpid_pkg::CFG_POSITION_GAINS: pos_gains = val;
      cpid_pkg::CFG_OUTPUT_LIMIT:   out_lim   = val[cpid_pkg::LIM_W-1:0];
      cpid_pkg::CFG_INTEG_CLAMP:    integ_lim = val[cpid_pkg::LIM_W-1:0];
      cpid_pkg::CFG_POS_DEADBAND:   pos_db    = val[cpid_pkg::DB_W-1:0];
      default: ;
    endcase
  endtask

  // Block until no transfer is pending or outstanding, then let it settle
  task automatic wait_idle();
    do @(posedge clk);
    while (cmd_queue.size() != 0 || in_valid || voltage_expect_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic cpid_pkg::in_item_t mk(logic op, int m, int tgt, int ang, int spd);
    cpid_pkg::in_item_t c;
    c.op             = op;
    c.motor_id       = 2'(m);
    c.target         = 16'(tgt);
    c.measured_angle = 13'(ang);
    c.measured_speed = 16'(spd);
    return c;
  endfunction

  // Random item; about half track the target closely so the loops stay in range
  function automatic cpid_pkg::in_item_t rand_cmd();
    cpid_pkg::in_item_t c;
    int                 d;
    c.op             = ($urandom_range(0, 1) == 1) ? cpid_pkg::OP_POSITION
                                                   : cpid_pkg::OP_SPEED;
    c.motor_id       = 2'($urandom_range(0, 3));
    c.target         = 16'($urandom());
    c.measured_angle = 13'($urandom());
    c.measured_speed = 16'($urandom());
    if ($urandom_range(0, 9) < 5) begin
      d = int'($urandom_range(0, 100)) - 50;
      if (c.op == cpid_pkg::OP_POSITION) c.target = 16'(int'(c.measured_angle) + d);
      else c.measured_speed = 16'(int'($signed(c.target)) + d);
    end
    return c;
  endfunction

  function automatic logic [cpid_pkg::GAIN_W-1:0] rand_gains();
    logic [cpid_pkg::GAIN_W-1:0] g;
    case ($urandom_range(0, 5))
      0: g = '0;
      1: g = '1;
      2: begin
        g[31:0]  = $urandom();
        g[47:32] = 16'($urandom());
      end
      default: g = {16'($urandom_range(0, 1024)), 16'($urandom_range(0, 2048)),
                    16'($urandom_range(0, 4096))};
    endcase
    return g;
  endfunction

  function automatic logic [cpid_pkg::GAIN_W-1:0] rand_limit(int max);
    case ($urandom_range(0, 4))
      0:       return cpid_pkg::GAIN_W'(0);
      1:       return cpid_pkg::GAIN_W'(max);
      2:       return cpid_pkg::GAIN_W'($urandom_range(1, 200));
      default: return cpid_pkg::GAIN_W'($urandom_range(0, max));
    endcase
  endfunction

  // Stimulus sequence
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: error extremes, deadband edges, every motor
    cmd_queue.push_back(mk(cpid_pkg::OP_SPEED, 0, 0, 0, 0));
    cmd_queue.push_back(mk(cpid_pkg::OP_SPEED, 1, 32767, 0, -32768));
    cmd_queue.push_back(mk(cpid_pkg::OP_SPEED, 2, -32768, 8191, 32767));
    cmd_queue.push_back(mk(cpid_pkg::OP_SPEED, 3, 100, 0, 95));
    cmd_queue.push_back(mk(cpid_pkg::OP_POSITION, 0, 10, 0, 0));
    cmd_queue.push_back(mk(cpid_pkg::OP_POSITION, 0, 8191, 0, 0));
    cmd_queue.push_back(mk(cpid_pkg::OP_POSITION, 1, -32768, 8191, 32767));
    cmd_queue.push_back(mk(cpid_pkg::OP_POSITION, 2, 32767, 0, -32768));
    cmd_queue.push_back(mk(cpid_pkg::OP_POSITION, 3, 100, 80, 0));
    cmd_queue.push_back(mk(cpid_pkg::OP_POSITION, 3, 100, 81, 0));
    cmd_queue.push_back(mk(cpid_pkg::OP_POSITION, 2, 8191, 8191, 5));
    wait_idle();

    // Every register at its maximum
    write_reg(cpid_pkg::CFG_SPEED_GAINS, '1);
    write_reg(cpid_pkg::CFG_POSITION_GAINS, '1);
    write_reg(cpid_pkg::CFG_OUTPUT_LIMIT, cpid_pkg::GAIN_W'(32767));
    write_reg(cpid_pkg::CFG_INTEG_CLAMP, cpid_pkg::GAIN_W'(32767));
    write_reg(cpid_pkg::CFG_POS_DEADBAND, cpid_pkg::GAIN_W'(8191));
    n_settings++;
    cmd_queue.push_back(mk(cpid_pkg::OP_POSITION, 0, 0, 8191, 0));
    cmd_queue.push_back(mk(cpid_pkg::OP_POSITION, 0, 0, 8190, 0));
    cmd_queue.push_back(mk(cpid_pkg::OP_POSITION, 1, -32768, 8191, -32768));
    cmd_queue.push_back(mk(cpid_pkg::OP_SPEED, 2, 32767, 0, -32768));
    cmd_queue.push_back(mk(cpid_pkg::OP_SPEED, 2, -32768, 0, 32767));
    cmd_queue.push_back(mk(cpid_pkg::OP_SPEED, 3, 1, 0, 0));
    wait_idle();

    // Zero limits, zero deadband, zero position gains
    write_reg(cpid_pkg::CFG_SPEED_GAINS, cpid_pkg::SPEED_GAINS_RST);
    write_reg(cpid_pkg::CFG_POSITION_GAINS, '0);
    write_reg(cpid_pkg::CFG_OUTPUT_LIMIT, '0);
    write_reg(cpid_pkg::CFG_INTEG_CLAMP, '0);
    write_reg(cpid_pkg::CFG_POS_DEADBAND, '0);
    n_settings++;
    cmd_queue.push_back(mk(cpid_pkg::OP_SPEED, 0, 5000, 0, -3000));
    cmd_queue.push_back(mk(cpid_pkg::OP_POSITION, 1, 0, 0, 100));
    cmd_queue.push_back(mk(cpid_pkg::OP_POSITION, 2, 4000, 100, -100));
    cmd_queue.push_back(mk(cpid_pkg::OP_SPEED, 3, -32768, 0, 32767));
    wait_idle();

    // Random phases, each under fresh register values
    for (int p = 0; p < 5; p++) begin
      write_reg(cpid_pkg::CFG_SPEED_GAINS, rand_gains());
      write_reg(cpid_pkg::CFG_POSITION_GAINS, rand_gains());
      write_reg(cpid_pkg::CFG_OUTPUT_LIMIT, rand_limit(32767));
      write_reg(cpid_pkg::CFG_INTEG_CLAMP, rand_limit(32767));
      write_reg(cpid_pkg::CFG_POS_DEADBAND, rand_limit(8191));
      n_settings++;
      for (int i = 0; i < 100; i++) cmd_queue.push_back(rand_cmd());
      // long receiver hold-off while the driver keeps offering
      if (p == 1 || p == 3) begin
        repeat ($urandom_range(5, 40)) @(posedge clk);
        hold_req++;
      end
      wait_idle();
    end

    $display("Summary: %0d transfers in, %0d results checked (%0d in deadband), %0d settings.",
             n_sent, n_checked, n_dead, n_settings);
    $display("Receiver held off twice for %0d cycles with the input kept busy.", HOLD_LEN);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", err_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
